[rtl/bets_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the brace entity token scanner.
// No dependencies.
package bets_pkg;

  // Scanner modes, one-hot
  typedef enum logic [7:0] {
    M_BLANK      = 8'b0000_0001,
    M_COMMENT    = 8'b0000_0010,
    M_KEY        = 8'b0000_0100,
    M_AFTER_KEY  = 8'b0000_1000,
    M_VALUE      = 8'b0001_0000,
    M_OTHER      = 8'b0010_0000,
    M_BARE       = 8'b0100_0000,
    M_COMMENT_AK = 8'b1000_0000
  } mode_t;

  typedef enum logic [3:0] {
    EV_IGNORED     = 4'd0,
    EV_OPEN        = 4'd1,
    EV_CLOSE       = 4'd2,
    EV_KEY_START   = 4'd3,
    EV_KEY_BYTE    = 4'd4,
    EV_KEY_END     = 4'd5,
    EV_VALUE_START = 4'd6,
    EV_VALUE_BYTE  = 4'd7,
    EV_VALUE_END   = 4'd8,
    EV_KEY_DROPPED = 4'd9
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_STRAY    = 3'd1,
    ERR_UNTERM   = 3'd2,
    ERR_NO_VALUE = 3'd3,
    ERR_OPEN_END = 3'd4
  } err_t;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
           (c == CH_FF) || (c == CH_VT);
  endfunction

endpackage

[rtl/brace_entity_token_scanner.sv]
`timescale 1ns / 1ps
// Each result is registered into the result queue when its byte is accepted.
// Throughput: one byte per clock while item_ready is high; a byte that yields
// two results (a dropped key followed by its own event) puts both on the single
// result port in turn; a three-entry queue absorbs that and output stalls.
// Reset (rst, synchronous): blank mode, line 1, depth 0, no error, queue empty.
// The end-of-data marker also returns the scan state to these values.
module brace_entity_token_scanner #(
  parameter int LINE_BITS  = 24,
  parameter int DEPTH_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  action,
  input  logic [7:0]            data_byte,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [3:0]            event_res,
  output logic [7:0]            text_byte,
  output logic [LINE_BITS-1:0]  line_number,
  output logic [DEPTH_BITS-1:0] brace_depth,
  output logic [2:0]            first_error,
  output logic                  last_of_run
);
  import bets_pkg::*;

  localparam int QDEPTH = 3;
  localparam logic [LINE_BITS-1:0]  LINE_MAX  = '1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  typedef struct packed {
    logic [3:0]            ev;
    logic [7:0]            text;
    logic [LINE_BITS-1:0]  line;
    logic [DEPTH_BITS-1:0] depth;
    logic [2:0]            err;
    logic                  last;
  } res_t;

  // Scan state
  mode_t                 scan_mode, scan_mode_next;
  logic                  slash_held, slash_held_next;
  logic [LINE_BITS-1:0]  line_count, line_count_next;
  logic [DEPTH_BITS-1:0] nest_depth, nest_depth_next;
  logic [2:0]            error_code, error_code_next;

  // Result queue
  res_t       q [QDEPTH];
  res_t       q_next [QDEPTH];
  logic [1:0] count, count_next;

  logic       acc, pop;
  logic [1:0] rem;
  res_t       res0, res1;
  logic       two;

  // Combinational scan of one byte
  logic   run_bare, run_blank, pre_drop, line_up, stray;
  event_t ev_main;
  logic [7:0] byte_main;
  logic [2:0] err_new;

  assign pop        = (count != 2'd0) && result_ready;
  assign rem        = count - {1'b0, pop};
  assign item_ready = (rem <= 2'd1);
  assign acc        = item_valid && item_ready;

  always_comb begin
    scan_mode_next  = scan_mode;
    slash_held_next = slash_held;
    nest_depth_next = nest_depth;
    run_bare  = 1'b0;
    run_blank = 1'b0;
    pre_drop  = 1'b0;
    line_up   = 1'b0;
    stray     = 1'b0;
    ev_main   = EV_IGNORED;
    byte_main = 8'd0;
    err_new   = ERR_NONE;

    if (action == ACT_END) begin
      if (scan_mode == M_KEY || scan_mode == M_VALUE) begin
        err_new = ERR_UNTERM;
        ev_main = EV_KEY_DROPPED;
      end else if (scan_mode == M_OTHER) begin
        err_new = ERR_UNTERM;
      end else if (scan_mode == M_AFTER_KEY || scan_mode == M_COMMENT_AK) begin
        err_new = ERR_NO_VALUE;
        ev_main = EV_KEY_DROPPED;
      end else if (nest_depth != '0) begin
        err_new = ERR_OPEN_END;
      end
    end else begin
      if (slash_held) begin
        slash_held_next = 1'b0;
        if (data_byte == CH_SLASH) begin
          scan_mode_next = (scan_mode == M_AFTER_KEY) ? M_COMMENT_AK : M_COMMENT;
        end else begin
          pre_drop       = (scan_mode == M_AFTER_KEY);
          scan_mode_next = M_BARE;
          run_bare       = 1'b1;
        end
      end else begin
        unique case (scan_mode)
          M_BLANK: run_blank = 1'b1;
          M_BARE:  run_bare  = 1'b1;
          M_COMMENT, M_COMMENT_AK: begin
            if (data_byte == CH_LF) begin
              line_up        = 1'b1;
              scan_mode_next = (scan_mode == M_COMMENT_AK) ? M_AFTER_KEY : M_BLANK;
            end
          end
          M_KEY: begin
            if (data_byte == CH_QUOTE) begin
              scan_mode_next = M_AFTER_KEY;
              ev_main        = EV_KEY_END;
            end else begin
              line_up   = (data_byte == CH_LF);
              ev_main   = EV_KEY_BYTE;
              byte_main = data_byte;
            end
          end
          M_VALUE: begin
            if (data_byte == CH_QUOTE) begin
              scan_mode_next = M_BLANK;
              ev_main        = EV_VALUE_END;
            end else begin
              line_up   = (data_byte == CH_LF);
              ev_main   = EV_VALUE_BYTE;
              byte_main = data_byte;
            end
          end
          M_OTHER: begin
            if (data_byte == CH_QUOTE) begin
              scan_mode_next = M_BLANK;
            end else begin
              line_up = (data_byte == CH_LF);
            end
          end
          M_AFTER_KEY: begin
            if (data_byte == CH_LF) begin
              line_up = 1'b1;
            end else if (is_space(data_byte)) begin
              line_up = 1'b0;
            end else if (data_byte == CH_SLASH) begin
              slash_held_next = 1'b1;
            end else if (data_byte == CH_QUOTE) begin
              scan_mode_next = M_VALUE;
              ev_main        = EV_VALUE_START;
            end else begin
              pre_drop       = 1'b1;
              scan_mode_next = M_BLANK;
              run_blank      = 1'b1;
            end
          end
          default: scan_mode_next = M_BLANK;
        endcase
      end

      // A delimiter ends a bare token and is scanned as blank text
      if (run_bare) begin
        if (is_space(data_byte) || data_byte == CH_QUOTE || data_byte == CH_OPEN ||
            data_byte == CH_CLOSE) begin
          scan_mode_next = M_BLANK;
          run_blank      = 1'b1;
        end else if (data_byte == CH_SLASH) begin
          slash_held_next = 1'b1;
        end
      end

      if (run_blank) begin
        if (data_byte == CH_LF) begin
          line_up = 1'b1;
        end else if (is_space(data_byte)) begin
          line_up = 1'b0;
        end else if (data_byte == CH_SLASH) begin
          scan_mode_next  = M_BARE;
          slash_held_next = 1'b1;
        end else if (data_byte == CH_OPEN) begin
          if (nest_depth != DEPTH_MAX) begin
            nest_depth_next = nest_depth + 1'b1;
          end
          if (nest_depth_next == DEPTH_BITS'(1)) begin
            ev_main = EV_OPEN;
          end
        end else if (data_byte == CH_CLOSE) begin
          if (nest_depth == '0) begin
            stray = 1'b1;
          end else begin
            nest_depth_next = nest_depth - 1'b1;
            if (nest_depth_next == '0) begin
              ev_main = EV_CLOSE;
            end
          end
        end else if (data_byte == CH_QUOTE) begin
          if (nest_depth == DEPTH_BITS'(1)) begin
            scan_mode_next = M_KEY;
            ev_main        = EV_KEY_START;
          end else begin
            scan_mode_next = M_OTHER;
          end
        end else begin
          scan_mode_next = M_BARE;
        end
      end

      // The dropped key is recorded before anything the byte itself causes
      priority if (pre_drop) begin
        err_new = ERR_NO_VALUE;
      end else if (stray) begin
        err_new = ERR_STRAY;
      end else begin
        err_new = ERR_NONE;
      end
    end

    line_count_next  = (line_up && line_count != LINE_MAX) ? line_count + 1'b1 : line_count;
    error_code_next  = (error_code == ERR_NONE) ? err_new : error_code;
  end

  always_comb begin
    two = (action == ACT_DATA) && pre_drop;

    res1.ev    = ev_main;
    res1.text  = byte_main;
    res1.line  = line_count_next;
    res1.depth = nest_depth_next;
    res1.err   = error_code_next;
    res1.last  = 1'b1;

    res0      = res1;
    if (two) begin
      res0.ev   = EV_KEY_DROPPED;
      res0.text = 8'd0;
      res0.last = 1'b0;
    end
  end

  // Shift out the head on a pop, then append this transaction's results
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_next[i] = q[i+1];
      end else begin
        q_next[i] = q[i];
      end
      if (acc && rem == 2'(i)) begin
        q_next[i] = res0;
      end
      if (acc && two && (rem + 2'd1) == 2'(i)) begin
        q_next[i] = res1;
      end
    end
    count_next = rem + (acc ? (two ? 2'd2 : 2'd1) : 2'd0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
    if (rst) begin
      count      <= 2'd0;
      scan_mode  <= M_BLANK;
      slash_held <= 1'b0;
      line_count <= LINE_BITS'(1);
      nest_depth <= '0;
      error_code <= ERR_NONE;
    end else begin
      count <= count_next;
      if (acc) begin
        if (action == ACT_END) begin
          // Start over for the next file
          scan_mode  <= M_BLANK;
          slash_held <= 1'b0;
          line_count <= LINE_BITS'(1);
          nest_depth <= '0;
          error_code <= ERR_NONE;
        end else begin
          scan_mode  <= scan_mode_next;
          slash_held <= slash_held_next;
          line_count <= line_count_next;
          nest_depth <= nest_depth_next;
          error_code <= error_code_next;
        end
      end
    end
  end

  assign result_valid = (count != 2'd0);
  assign event_res    = q[0].ev;
  assign text_byte    = q[0].text;
  assign line_number  = q[0].line;
  assign brace_depth  = q[0].depth;
  assign first_error  = q[0].err;
  assign last_of_run  = q[0].last;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for brace_entity_token_scanner: random entity files through
// a handshake driver, with a tag predictor and scoreboard kept inside the testbench.
// Depends on bets_pkg and the scanner RTL only.
module tb_top;
  import bets_pkg::*;

  localparam int LINE_BITS   = 24;
  localparam int DEPTH_BITS  = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 130;

  localparam int SEND_IDLE[4]  = '{0, 77, 0, 30};
  localparam int RECV_STALL[4] = '{0, 0, 77, 30};

  typedef struct {
    event_t                ev;
    logic [7:0]            txt;
    logic [LINE_BITS-1:0]  line;
    logic [DEPTH_BITS-1:0] depth;
    err_t                  err;
    logic                  last;
  } tag_t;

  // Tracks the scanner state and queues the tags each accepted transaction should produce.
  class tag_board;
    mode_t                 mode;
    bit                    slash;
    logic [LINE_BITS-1:0]  line_cnt;
    logic [DEPTH_BITS-1:0] depth;
    err_t                  err;
    event_t                step_ev[$];
    logic [7:0]            step_txt[$];
    tag_t                  pending_tags[$];
    int                    failures;

    function new();
      clear();
      failures = 0;
    endfunction

    function void clear();
      mode     = M_BLANK;
      slash    = 1'b0;
      line_cnt = LINE_BITS'(1);
      depth    = '0;
      err      = ERR_NONE;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function bit is_ws(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
             c == CH_FF || c == CH_VT;
    endfunction

    function void emit(event_t e, logic [7:0] t);
      if (step_ev.size() < 2) begin
        step_ev.push_back(e);
        step_txt.push_back(t);
      end
    endfunction

    function void bump();
      if (line_cnt != '1) line_cnt++;
    endfunction

    function void flag(err_t e);
      if (err == ERR_NONE) err = e;
    endfunction

    function void blank(logic [7:0] c);
      if (c == CH_LF) begin
        bump();
        emit(EV_IGNORED, 8'h00);
      end else if (is_ws(c)) begin
        emit(EV_IGNORED, 8'h00);
      end else if (c == CH_SLASH) begin
        mode  = M_BARE;
        slash = 1'b1;
        emit(EV_IGNORED, 8'h00);
      end else if (c == CH_OPEN) begin
        if (depth != '1) depth++;
        emit((depth == 1) ? EV_OPEN : EV_IGNORED, 8'h00);
      end else if (c == CH_CLOSE) begin
        if (depth == 0) begin
          flag(ERR_STRAY);
          emit(EV_IGNORED, 8'h00);
        end else begin
          depth--;
          emit((depth == 0) ? EV_CLOSE : EV_IGNORED, 8'h00);
        end
      end else if (c == CH_QUOTE) begin
        if (depth == 1) begin
          mode = M_KEY;
          emit(EV_KEY_START, 8'h00);
        end else begin
          mode = M_OTHER;
          emit(EV_IGNORED, 8'h00);
        end
      end else begin
        mode = M_BARE;
        emit(EV_IGNORED, 8'h00);
      end
    endfunction

    function void bare(logic [7:0] c);
      if (is_ws(c) || c == CH_QUOTE || c == CH_OPEN || c == CH_CLOSE) begin
        mode = M_BLANK;
        blank(c);
      end else begin
        if (c == CH_SLASH) slash = 1'b1;
        emit(EV_IGNORED, 8'h00);
      end
    endfunction

    function void scan_byte(logic [7:0] c);
      if (slash) begin
        slash = 1'b0;
        if (c == CH_SLASH) begin
          mode = (mode == M_AFTER_KEY) ? M_COMMENT_AK : M_COMMENT;
          emit(EV_IGNORED, 8'h00);
          return;
        end
        // a held slash that starts no comment drops a pending key
        if (mode == M_AFTER_KEY) begin
          flag(ERR_NO_VALUE);
          emit(EV_KEY_DROPPED, 8'h00);
        end
        mode = M_BARE;
        bare(c);
        return;
      end
      case (mode)
        M_BLANK: blank(c);
        M_BARE:  bare(c);
        M_COMMENT, M_COMMENT_AK: begin
          if (c == CH_LF) begin
            bump();
            mode = (mode == M_COMMENT_AK) ? M_AFTER_KEY : M_BLANK;
          end
          emit(EV_IGNORED, 8'h00);
        end
        M_KEY: begin
          if (c == CH_QUOTE) begin
            mode = M_AFTER_KEY;
            emit(EV_KEY_END, 8'h00);
          end else begin
            if (c == CH_LF) bump();
            emit(EV_KEY_BYTE, c);
          end
        end
        M_VALUE: begin
          if (c == CH_QUOTE) begin
            mode = M_BLANK;
            emit(EV_VALUE_END, 8'h00);
          end else begin
            if (c == CH_LF) bump();
            emit(EV_VALUE_BYTE, c);
          end
        end
        M_OTHER: begin
          if (c == CH_QUOTE) mode = M_BLANK;
          else if (c == CH_LF) bump();
          emit(EV_IGNORED, 8'h00);
        end
        default: begin
          if (c == CH_LF) begin
            bump();
            emit(EV_IGNORED, 8'h00);
          end else if (is_ws(c)) begin
            emit(EV_IGNORED, 8'h00);
          end else if (c == CH_SLASH) begin
            slash = 1'b1;
            emit(EV_IGNORED, 8'h00);
          end else if (c == CH_QUOTE) begin
            mode = M_VALUE;
            emit(EV_VALUE_START, 8'h00);
          end else begin
            flag(ERR_NO_VALUE);
            emit(EV_KEY_DROPPED, 8'h00);
            mode = M_BLANK;
            blank(c);
          end
        end
      endcase
    endfunction

    function void end_of_file();
      event_t code;
      code = EV_IGNORED;
      if (mode == M_KEY || mode == M_VALUE) begin
        flag(ERR_UNTERM);
        code = EV_KEY_DROPPED;
      end else if (mode == M_OTHER) begin
        flag(ERR_UNTERM);
      end else if (mode == M_AFTER_KEY || mode == M_COMMENT_AK) begin
        flag(ERR_NO_VALUE);
        code = EV_KEY_DROPPED;
      end
      if (depth != 0) flag(ERR_OPEN_END);
      emit(code, 8'h00);
    endfunction

    function void note_item(logic act, logic [7:0] b);
      tag_t t;
      step_ev.delete();
      step_txt.delete();
      if (act == ACT_END) end_of_file();
      else scan_byte(b);
      for (int k = 0; k < step_ev.size(); k++) begin
        t.ev    = step_ev[k];
        t.txt   = step_txt[k];
        t.line  = line_cnt;
        t.depth = depth;
        t.err   = err;
        t.last  = (k == step_ev.size() - 1);
        pending_tags.push_back(t);
      end
      if (act == ACT_END) clear();
    endfunction

    function void check_tag(logic [3:0] ev, logic [7:0] txt, logic [LINE_BITS-1:0] ln,
                            logic [DEPTH_BITS-1:0] dp, logic [2:0] fe, logic lst);
      tag_t want;
      if (pending_tags.size() == 0) begin
        report($sformatf("unexpected result: event %0d text %h line %0d depth %0d",
                         ev, txt, ln, dp));
        return;
      end
      want = pending_tags.pop_front();
      if (ev !== want.ev || txt !== want.txt || ln !== want.line || dp !== want.depth ||
          fe !== want.err || lst !== want.last)
        report($sformatf({"mismatch (expected/actual): event %0d/%0d text %h/%h ",
                          "line %0d/%0d depth %0d/%0d error %0d/%0d last %0d/%0d"},
                         want.ev, ev, want.txt, txt, want.line, ln, want.depth, dp,
                         want.err, fe, want.last, lst));
    endfunction

    function void report_leftovers();
      tag_t want;
      while (pending_tags.size() != 0) begin
        want = pending_tags.pop_front();
        report($sformatf("result never arrived: event %0d line %0d", want.ev, want.line));
      end
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  action       = 1'b0;
  logic [7:0]            data_byte    = 8'h00;
  logic                  result_ready = 1'b0;
  logic                  item_ready;
  logic                  result_valid;
  logic [3:0]            event_res;
  logic [7:0]            text_byte;
  logic [LINE_BITS-1:0]  line_number;
  logic [DEPTH_BITS-1:0] brace_depth;
  logic [2:0]            first_error;
  logic                  last_of_run;

  tag_board   board = new();
  int         send_idle = 0;
  int         recv_stall = 0;
  int         stalled = 0;
  logic       stim_act[$];
  logic [7:0] stim_byte[$];

  brace_entity_token_scanner #(
    .LINE_BITS (LINE_BITS),
    .DEPTH_BITS(DEPTH_BITS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .action      (action),
    .data_byte   (data_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .event_res   (event_res),
    .text_byte   (text_byte),
    .line_number (line_number),
    .brace_depth (brace_depth),
    .first_error (first_error),
    .last_of_run (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ready <= !rst && ($urandom_range(99) >= recv_stall);
  end

  // Sample both handshakes mid-cycle: the values are settled and the transaction
  // completes at the next rising edge. Note the input before checking the output.
  always @(negedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready === 1'b1) board.note_item(action, data_byte);
      if (result_valid === 1'b1 && result_ready)
        board.check_tag(event_res, text_byte, line_number, brace_depth, first_error,
                        last_of_run);
      if ((item_valid && item_ready === 1'b1) || (result_valid === 1'b1 && result_ready))
        stalled = 0;
      else
        stalled++;
    end
  end

  initial begin : watchdog
    wait (stalled >= STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic void put(logic a, logic [7:0] b);
    stim_act.push_back(a);
    stim_byte.push_back(b);
  endfunction

  function automatic void put_byte(logic [7:0] b);
    put(ACT_DATA, b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_gap();
    logic [7:0] b;
    repeat ($urandom_range(3)) begin
      case ($urandom_range(5))
        0: put_byte(CH_SPACE);
        1: put_byte(CH_TAB);
        2: put_byte(CH_CR);
        3: put_byte(CH_LF);
        4: put_byte(CH_FF);
        default: put_byte(CH_VT);
      endcase
    end
    if ($urandom_range(9) == 0) begin
      put_byte(CH_SLASH);
      put_byte(CH_SLASH);
      repeat ($urandom_range(4)) begin
        b = 8'($urandom_range(255));
        if (b == CH_LF) b = CH_SPACE;
        put_byte(b);
      end
      put_byte(CH_LF);
    end
  endfunction

  function automatic void put_str();
    logic [7:0] b;
    put_byte(CH_QUOTE);
    repeat ($urandom_range(5)) begin
      b = 8'($urandom_range(255));
      while (b == CH_QUOTE) b = 8'($urandom_range(255));
      put_byte(b);
    end
    put_byte(CH_QUOTE);
  endfunction

  // Token of letters and punctuation, now and then with a slash inside
  function automatic void put_bare();
    repeat (1 + $urandom_range(3)) put_byte(8'(8'h41 + $urandom_range(57)));
    if ($urandom_range(3) == 0) begin
      put_byte(CH_SLASH);
      put_byte(8'(8'h41 + $urandom_range(57)));
    end
  endfunction

  function automatic void put_entity();
    put_byte(CH_OPEN);
    put_gap();
    repeat ($urandom_range(3)) begin
      put_str();
      put_gap();
      case ($urandom_range(9))
        0: put_bare();
        1: begin
          put_byte(CH_SLASH);
          put_bare();
        end
        2: put_byte(CH_CLOSE);
        default: put_str();
      endcase
      put_gap();
      if ($urandom_range(7) == 0) begin
        put_byte(CH_OPEN);
        put_gap();
        put_str();
        put_gap();
        put_bare();
        put_gap();
        put_byte(CH_CLOSE);
        put_gap();
      end
    end
    put_byte(CH_CLOSE);
  endfunction

  // Mostly well-formed files, some noise, some cut short before the end marker
  function automatic void put_file();
    int first;
    first = stim_act.size();
    repeat (1 + $urandom_range(2)) begin
      put_gap();
      if ($urandom_range(5) == 0)
        repeat (1 + $urandom_range(7)) put_byte(8'($urandom_range(255)));
      else
        put_entity();
    end
    put_gap();
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(stim_act.size() - first - 1)) begin
        void'(stim_act.pop_back());
        void'(stim_byte.pop_back());
      end
    end
    put(ACT_END, 8'($urandom_range(255)));
  endfunction

  task automatic send(input logic act, input logic [7:0] b);
    logic fire;
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      action     <= 1'($urandom_range(1));
      data_byte  <= 8'($urandom_range(255));
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    data_byte  <= b;
    fire = 1'b0;
    while (!fire) begin
      @(negedge clk);
      fire = (item_ready === 1'b1);
      @(posedge clk);
    end
  endtask

  initial begin : main
    int   start;
    logic a;
    logic [7:0] b;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = SEND_IDLE[ph];
      recv_stall = RECV_STALL[ph];
      if (ph == 0) begin
        // key with a newline, comment before the value, extreme byte in the value
        put_text("{\"\n\"//\n\"");
        put_byte(8'hFF);
        // empty key dropped by a lone slash
        put_text("\"\"\"/x");
        put_byte(CH_VT);
        // string at depth 2, two closes, then a stray close
        put_text("{\"\"}}}");
        put_byte(CH_FF);
        put_byte(CH_CR);
        put_byte(8'h00);
        put_byte(CH_TAB);
        put_text("/a");
        put_byte(CH_SPACE);
        put(ACT_END, 8'hFF);
        // unterminated key at end of data
        put_text("{\"k");
        put(ACT_END, 8'h00);
        // saturate the depth, count down from the top, end inside an entity
        repeat (256) put_byte(CH_OPEN);
        repeat (3) put_byte(CH_CLOSE);
        put(ACT_END, 8'h5A);
      end
      start = stim_act.size();
      while (stim_act.size() - start < PHASE_ITEMS) put_file();
      while (stim_act.size() != 0) begin
        a = stim_act.pop_front();
        b = stim_byte.pop_front();
        send(a, b);
      end
      item_valid <= 1'b0;
      while (board.pending_tags.size() != 0) @(posedge clk);
    end
    repeat (20) @(posedge clk);
    board.report_leftovers();
    if (board.failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
rtl/bets_pkg.sv
rtl/brace_entity_token_scanner.sv
verif/tb_top.sv
